/* src/rfft_pkg.sv */
// Shared types, constants and twiddle-table math for the radix-2 FFT/IFFT block.
// No dependencies; every other file imports it.
`default_nettype none

package rfft_pkg;

	localparam int MAX_POINTS_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF  = 24;
	localparam int TWIDDLE_BITS_DEF = 16;
	localparam int DATA_BITS        = 36;
	localparam int CFG_DATA_BITS    = 4;
	localparam int QUEUE_DEPTH      = 2;
	localparam logic [3:0] LOG2_RESET = 4'd10;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic CFG_INVERSE = 1'b0;
	localparam logic CFG_LOG2    = 1'b1;

	// control part of one queued request
	typedef struct packed {
		logic       is_read;
		logic       last;
		logic       inv;
		logic [4:0] lg;
	} cmd_ctrl_t;

	localparam int CTRL_BITS = $bits(cmd_ctrl_t);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_PA,
		ST_PB,
		ST_PC,
		ST_PD,
		ST_BA,
		ST_BB,
		ST_BC,
		ST_BD,
		ST_BE,
		ST_BF,
		ST_SA,
		ST_SB
	} back_state_t;

	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned PI_Q30  = 64'd3373259426;

	// quotient of num by a small nonzero d, shift and subtract
	function automatic longint unsigned udiv_small(input longint unsigned num,
			input longint unsigned d);
		longint unsigned q;
		longint unsigned rem;
		q   = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= d) begin
				rem  = rem - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// cos and sin in Q30 of x (Q30, 0..pi/4), truncated Taylor series
	function automatic logic [127:0] sincos_q30(input longint unsigned x);
		longint unsigned x2;
		longint unsigned ct;
		longint unsigned st;
		longint unsigned dc;
		longint unsigned ds;
		longint          cs;
		longint          ss;
		x2 = (x * x) >> 30;
		ct = Q30_ONE;
		st = x;
		cs = longint'(Q30_ONE);
		ss = longint'(x);
		for (int i = 1; i <= 12; i++) begin
			dc = 64'((2 * i - 1) * (2 * i));
			ds = 64'((2 * i) * (2 * i + 1));
			ct = udiv_small((ct * x2) >> 30, dc);
			st = udiv_small((st * x2) >> 30, ds);
			if (i % 2 == 1) begin
				cs = cs - longint'(ct);
				ss = ss - longint'(st);
			end else begin
				cs = cs + longint'(ct);
				ss = ss + longint'(st);
			end
		end
		return {cs, ss};
	endfunction

	function automatic longint quant(input longint v, input int frac);
		longint maxv;
		longint r;
		longint w;
		maxv = (64'sd1 << frac) - 1;
		w = (v < 0) ? 64'sd0 : v;
		r = (w + (64'sd1 << (29 - frac))) >>> (30 - frac);
		return (r > maxv) ? maxv : r;
	endfunction

	// twiddle k of 2**lg points: {cos[31:0], sin[31:0]} of 2*pi*k/2**lg, both two's complement
	function automatic logic [63:0] tw_entry(input int k, input int lg, input int frac);
		longint unsigned a;
		longint unsigned n;
		longint unsigned n2;
		longint unsigned r;
		logic [1:0]      qq;
		logic [127:0]    sc;
		longint          c;
		longint          s;
		longint          cq;
		longint          sq;
		longint          cv;
		longint          sv;
		a  = 64'd8 * longint'(unsigned'(k));
		n  = 64'd1 << lg;
		n2 = n << 1;
		qq = 2'(a >> (lg + 1));
		r  = a & (n2 - 1);
		if (r <= n) begin
			sc = sincos_q30((PI_Q30 * r) >> (lg + 2));
			c  = longint'(sc[127:64]);
			s  = longint'(sc[63:0]);
		end else begin
			sc = sincos_q30((PI_Q30 * (n2 - r)) >> (lg + 2));
			s  = longint'(sc[127:64]);
			c  = longint'(sc[63:0]);
		end
		cq = quant(c, frac);
		sq = quant(s, frac);
		unique case (qq)
			2'd0: begin cv = cq;  sv = sq;  end
			2'd1: begin cv = -sq; sv = cq;  end
			2'd2: begin cv = -cq; sv = -sq; end
			2'd3: begin cv = sq;  sv = -cq; end
		endcase
		return {cv[31:0], sv[31:0]};
	endfunction

	function automatic logic [DATA_BITS-1:0] sat_data(input logic signed [DATA_BITS+2:0] v);
		if (v > $signed({4'b0000, {(DATA_BITS - 1){1'b1}}}))
			return {1'b0, {(DATA_BITS - 1){1'b1}}};
		else if (v < $signed({4'b1111, {(DATA_BITS - 1){1'b0}}}))
			return {1'b1, {(DATA_BITS - 1){1'b0}}};
		else
			return v[DATA_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

/* src/rfft_front.sv */
// Front end: input handshake, configuration registers, request classification.
// Depends on rfft_pkg; feeds rfft_queue.
`default_nettype none

module rfft_front
	import rfft_pkg::*;
#(
	parameter int MaxPoints  = MAX_POINTS_DEF,
	parameter int SampleBits = SAMPLE_BITS_DEF,
	localparam int AW  = $clog2(MaxPoints),
	localparam int IDW = ((2 * SampleBits + 7) / 8) * 8,
	localparam int CW  = CTRL_BITS + 2 * SampleBits
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IDW-1:0]           s_tdata,
	input  logic                     s_tuser,
	input  logic                     s_tlast,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                     clearing,
	output logic                     push_valid,
	input  logic                     push_ready,
	output logic [CW-1:0]            push_data
);

	logic       inv_q;
	logic [3:0] lg_q;
	logic [4:0] eff_lg;
	cmd_ctrl_t  ctrl;
	logic [SampleBits-1:0] im_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= 1'b0;
			lg_q  <= LOG2_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INVERSE: inv_q <= cfg_wdata[0];
				CFG_LOG2:    lg_q  <= cfg_wdata[3:0];
			endcase
		end
	end

	always_comb begin
		if (lg_q < 4'd2)
			eff_lg = 5'd2;
		else if (int'(lg_q) > AW)
			eff_lg = 5'(AW);
		else
			eff_lg = {1'b0, lg_q};
	end

	// imaginary input only counts in inverse mode
	assign im_sel = inv_q ? s_tdata[2*SampleBits-1:SampleBits] : '0;

	always_comb begin
		ctrl.is_read = (s_tuser == REQ_READ);
		ctrl.last    = s_tlast;
		ctrl.inv     = inv_q;
		ctrl.lg      = eff_lg;
	end

	assign push_data  = {ctrl, s_tdata[SampleBits-1:0], im_sel};
	assign push_valid = s_tvalid & ~clearing;
	assign s_tready   = push_ready & ~clearing;

endmodule

`default_nettype wire

/* src/rfft_queue.sv */
// Short request queue between the front end and the transform engine.
// Depends on rfft_pkg for the default depth.
`default_nettype none

module rfft_queue
	import rfft_pkg::*;
#(
	parameter int Width = 8,
	parameter int Depth = QUEUE_DEPTH,
	localparam int PW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [Width-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop,
	output logic [Width-1:0] pop_data
);

	logic [Width-1:0] slot_q [Depth];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != (PW + 1)'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!do_push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

/* src/rfft_twiddle.sv */
// Twiddle ROM for the largest size, registered read, conjugated in inverse mode.
// Depends on rfft_pkg (tw_entry).
`default_nettype none

module rfft_twiddle
	import rfft_pkg::*;
#(
	parameter int MaxPoints   = MAX_POINTS_DEF,
	parameter int TwiddleBits = TWIDDLE_BITS_DEF,
	localparam int AW   = $clog2(MaxPoints),
	localparam int HW   = AW - 1,
	localparam int Half = MaxPoints / 2
) (
	input  logic                          clk,
	input  logic [HW-1:0]                 k,
	input  logic                          inv,
	output logic signed [TwiddleBits-1:0] wr,
	output logic signed [TwiddleBits-1:0] wi
);

	logic [2*TwiddleBits-1:0]      rom [Half];
	logic signed [TwiddleBits-1:0] sv;
	logic signed [TwiddleBits-1:0] wr_q;
	logic signed [TwiddleBits-1:0] wi_q;

	for (genvar g = 0; g < Half; g++) begin : g_rom
		localparam logic [63:0] Entry = tw_entry(g, AW, TwiddleBits - 1);
		assign rom[g] = {Entry[32 +: TwiddleBits], Entry[0 +: TwiddleBits]};
	end

	assign sv = $signed(rom[k][TwiddleBits-1:0]);

	always_ff @(posedge clk) begin
		wr_q <= $signed(rom[k][2*TwiddleBits-1:TwiddleBits]);
		wi_q <= inv ? sv : -sv;
	end

	assign wr = wr_q;
	assign wi = wi_q;

endmodule

`default_nettype wire

/* src/rfft_back.sv */
// Transform engine: sample store, reordering, shared butterfly, scaling, bin reads.
// Depends on rfft_pkg and rfft_twiddle.
`default_nettype none

module rfft_back
	import rfft_pkg::*;
#(
	parameter int MaxPoints   = MAX_POINTS_DEF,
	parameter int SampleBits  = SAMPLE_BITS_DEF,
	parameter int TwiddleBits = TWIDDLE_BITS_DEF,
	localparam int AW   = $clog2(MaxPoints),
	localparam int HW   = AW - 1,
	localparam int DW   = DATA_BITS,
	localparam int MW   = 2 * DW,
	localparam int Frac = TwiddleBits - 1,
	localparam int PBW  = DW + TwiddleBits,
	localparam int CW   = CTRL_BITS + 2 * SampleBits,
	localparam int ODW  = ((2 * DW + AW + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  logic [CW-1:0]  q_data,
	output logic           q_pop,
	output logic           clearing,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [ODW-1:0] m_tdata,
	output logic           m_tlast
);

	localparam longint RndL = 64'sd1 << (Frac - 1);

	back_state_t st_q, st_next;

	logic [MW-1:0] mem_q [MaxPoints];
	logic [MW-1:0] mem_rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [AW-1:0] mem_ra;
	logic [MW-1:0] mem_wd;

	logic [AW:0]   lc_q;
	logic [AW-1:0] rp_q;
	logic          done_q;
	logic          inv_t_q;
	logic [4:0]    lg_t_q;
	logic [AW-1:0] i_q;
	logic [4:0]    stg_q;
	logic [MW-1:0] vi_q;
	logic [MW-1:0] a_q;
	logic [MW-1:0] b_q;
	logic signed [PBW-1:0]  pm1_q, pm2_q, pm3_q, pm4_q;
	logic signed [DW+1:0]   t_re_q, t_im_q;
	logic [DW-1:0] ore_q, oim_q;
	logic [AW-1:0] oidx_q, ridx_q;
	logic          olast_q, rlast_q, ovalid_q;

	// request decode
	cmd_ctrl_t     ctrl;
	logic [SampleBits-1:0] c_re, c_im;
	logic [AW:0]   c_n;
	logic [AW-1:0] c_mask;
	logic [AW:0]   eff_lc;
	logic          room;
	logic [AW-1:0] rd_idx;
	logic          out_free;

	// transform addressing
	logic [AW:0]   t_n;
	logic [AW-1:0] t_last_i;
	logic [HW-1:0] half_last;
	logic          last_stage;
	logic [AW-1:0] rev_full;
	logic [AW-1:0] pj;
	logic [HW-1:0] bi;
	logic [HW-1:0] smask;
	logic [HW-1:0] low;
	logic [AW-1:0] bp;
	logic [AW-1:0] bq;
	logic [HW-1:0] k_rom;
	logic          kz;

	logic signed [TwiddleBits-1:0] wr, wi;
	logic signed [DW-1:0] bre, bim, are, aim, sre;
	logic signed [PBW:0]  xre, xim;
	logic signed [DW+2:0] sum_re, sum_im, dif_re, dif_im;

	assign ctrl   = cmd_ctrl_t'(q_data[CW-1 -: CTRL_BITS]);
	assign c_re   = q_data[2*SampleBits-1:SampleBits];
	assign c_im   = q_data[SampleBits-1:0];
	assign c_n    = (AW + 1)'(1) << ctrl.lg;
	assign c_mask = AW'(c_n - 1'b1);
	assign eff_lc = done_q ? '0 : lc_q;
	assign room   = (eff_lc < c_n);
	assign rd_idx = rp_q & c_mask;
	assign out_free = ~ovalid_q | m_tready;

	assign t_n        = (AW + 1)'(1) << lg_t_q;
	assign t_last_i   = AW'(t_n - 1'b1);
	assign half_last  = HW'((t_n >> 1) - 1'b1);
	assign last_stage = (stg_q == lg_t_q - 5'd1);

	always_comb begin
		rev_full = '0;
		for (int b = 0; b < AW; b++)
			rev_full[AW-1-b] = i_q[b];
		pj = rev_full >> (AW - int'(lg_t_q));
	end

	// butterfly bi of stage s: p has a zero inserted at bit s, q = p + 2**s
	assign bi    = i_q[HW-1:0];
	assign smask = HW'((AW'(1) << stg_q) - 1'b1);
	assign low   = bi & smask;
	assign bp    = ((AW'(bi) >> stg_q) << (stg_q + 5'd1)) | AW'(low);
	assign bq    = bp | (AW'(1) << stg_q);
	assign k_rom = low << (5'(HW) - stg_q);
	assign kz    = (low == '0);

	rfft_twiddle #(
		.MaxPoints  (MaxPoints),
		.TwiddleBits(TwiddleBits)
	) u_twiddle (
		.clk(clk),
		.k  (k_rom),
		.inv(inv_t_q),
		.wr (wr),
		.wi (wi)
	);

	assign bre = $signed(b_q[MW-1:DW]);
	assign bim = $signed(b_q[DW-1:0]);
	assign are = $signed(a_q[MW-1:DW]);
	assign aim = $signed(a_q[DW-1:0]);
	assign sre = $signed(mem_rd_q[MW-1:DW]);
	assign xre = (PBW + 1)'(pm1_q) - (PBW + 1)'(pm2_q) + (PBW + 1)'(RndL);
	assign xim = (PBW + 1)'(pm3_q) + (PBW + 1)'(pm4_q) + (PBW + 1)'(RndL);
	assign sum_re = (DW + 3)'(are) + (DW + 3)'(t_re_q);
	assign sum_im = (DW + 3)'(aim) + (DW + 3)'(t_im_q);
	assign dif_re = (DW + 3)'(are) - (DW + 3)'(t_re_q);
	assign dif_im = (DW + 3)'(aim) - (DW + 3)'(t_im_q);

	// sample store
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_wa] <= mem_wd;
		mem_rd_q <= mem_q[mem_ra];
	end

	// next state
	always_comb begin
		st_next = st_q;
		unique case (st_q)
			ST_CLEAR: if (i_q == AW'(MaxPoints - 1)) st_next = ST_IDLE;
			ST_IDLE: begin
				if (q_valid) begin
					if (!ctrl.is_read && ctrl.last)
						st_next = ST_PA;
					else if (ctrl.is_read && done_q && out_free)
						st_next = ST_RD;
				end
			end
			ST_RD: st_next = ST_IDLE;
			ST_PA: begin
				if (i_q > pj)
					st_next = (i_q == t_last_i) ? ST_BA : ST_PA;
				else
					st_next = ST_PB;
			end
			ST_PB: st_next = ST_PC;
			ST_PC: st_next = ST_PD;
			ST_PD: st_next = (i_q == t_last_i) ? ST_BA : ST_PA;
			ST_BA: st_next = ST_BB;
			ST_BB: st_next = ST_BC;
			ST_BC: st_next = ST_BD;
			ST_BD: st_next = ST_BE;
			ST_BE: st_next = ST_BF;
			ST_BF: begin
				if (bi == half_last && last_stage)
					st_next = inv_t_q ? ST_SA : ST_IDLE;
				else
					st_next = ST_BA;
			end
			ST_SA: st_next = ST_SB;
			ST_SB: st_next = (i_q == t_last_i) ? ST_IDLE : ST_SA;
			default: st_next = ST_IDLE;
		endcase
	end

	// store and queue control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = i_q;
		mem_wd = '0;
		mem_ra = i_q;
		q_pop  = 1'b0;
		unique case (st_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE: begin
				mem_ra = rd_idx;
				if (q_valid && (!ctrl.is_read || !done_q || out_free))
					q_pop = 1'b1;
				if (q_valid && !ctrl.is_read && room) begin
					mem_we = 1'b1;
					mem_wa = eff_lc[AW-1:0];
					mem_wd = {DW'($signed(c_re)), DW'($signed(c_im))};
				end
			end
			ST_PB: mem_ra = pj;
			ST_PC: begin
				mem_we = 1'b1;
				mem_wd = ((AW + 1)'(pj) < lc_q) ? mem_rd_q : '0;
			end
			ST_PD: begin
				mem_we = 1'b1;
				mem_wa = pj;
				mem_wd = vi_q;
			end
			ST_BA: mem_ra = bp;
			ST_BB: mem_ra = bq;
			ST_BE: begin
				mem_we = 1'b1;
				mem_wa = bp;
				mem_wd = {sat_data(sum_re), sat_data(sum_im)};
			end
			ST_BF: begin
				mem_we = 1'b1;
				mem_wa = bq;
				mem_wd = {sat_data(dif_re), sat_data(dif_im)};
			end
			ST_SB: begin
				mem_we = 1'b1;
				mem_wd = {DW'(sre >>> lg_t_q), DW'(0)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLEAR;
			i_q      <= '0;
			stg_q    <= '0;
			lc_q     <= '0;
			rp_q     <= '0;
			done_q   <= 1'b0;
			inv_t_q  <= 1'b0;
			lg_t_q   <= 5'd2;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_next;
			if (st_q == ST_RD)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
			unique case (st_q)
				ST_CLEAR: i_q <= i_q + 1'b1;
				ST_IDLE: begin
					if (q_pop && !ctrl.is_read) begin
						lc_q <= eff_lc + (AW + 1)'(room);
						if (done_q) begin
							done_q <= 1'b0;
							rp_q   <= '0;
						end
						if (ctrl.last) begin
							inv_t_q <= ctrl.inv;
							lg_t_q  <= ctrl.lg;
							i_q     <= '0;
						end
					end else if (q_pop && done_q) begin
						rp_q <= (rd_idx + 1'b1) & c_mask;
					end
				end
				ST_PA: begin
					if (i_q > pj) begin
						if (i_q == t_last_i) begin
							i_q   <= '0;
							stg_q <= '0;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				ST_PD: begin
					if (i_q == t_last_i) begin
						i_q   <= '0;
						stg_q <= '0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_BF: begin
					if (bi == half_last) begin
						i_q <= '0;
						if (last_stage) begin
							if (!inv_t_q) begin
								done_q <= 1'b1;
								rp_q   <= '0;
							end
						end else begin
							stg_q <= stg_q + 5'd1;
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_SB: begin
					i_q <= i_q + 1'b1;
					if (i_q == t_last_i) begin
						done_q <= 1'b1;
						rp_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE) begin
			ridx_q  <= rd_idx;
			rlast_q <= (rd_idx == c_mask);
		end
		if (st_q == ST_RD) begin
			ore_q   <= mem_rd_q[MW-1:DW];
			oim_q   <= mem_rd_q[DW-1:0];
			oidx_q  <= ridx_q;
			olast_q <= rlast_q;
		end
		if (st_q == ST_PB)
			vi_q <= ((AW + 1)'(i_q) < lc_q) ? mem_rd_q : '0;
		if (st_q == ST_BB)
			a_q <= mem_rd_q;
		if (st_q == ST_BC) begin
			b_q   <= mem_rd_q;
			pm1_q <= wr * $signed(mem_rd_q[MW-1:DW]);
			pm2_q <= wi * $signed(mem_rd_q[DW-1:0]);
			pm3_q <= wi * $signed(mem_rd_q[MW-1:DW]);
			pm4_q <= wr * $signed(mem_rd_q[DW-1:0]);
		end
		if (st_q == ST_BD) begin
			t_re_q <= kz ? (DW + 2)'(bre) : xre[Frac +: DW + 2];
			t_im_q <= kz ? (DW + 2)'(bim) : xim[Frac +: DW + 2];
		end
	end

	assign clearing = (st_q == ST_CLEAR);
	assign m_tvalid = ovalid_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {(ODW - 2 * DW - AW)'(0), oidx_q, oim_q, ore_q};

endmodule

`default_nettype wire

/* src/radix2_fft_ifft.sv */
// Top level of the radix-2 decimation-in-time FFT/IFFT block.
// Depends on rfft_pkg, rfft_front, rfft_queue and rfft_back.
//
// Stream in samples as load requests (tuser 0); the one with tlast starts the
// transform over 2**log2_points points, zero-padding what never arrived and dropping
// samples past the size. Read requests (tuser 1) then return one bin each, in
// order, wrapping after the last bin; reads before any transform return nothing.
// The transform runs on one butterfly unit with a single-read, single-write sample
// store: bit-reversal reordering, then the butterfly stages, then, in inverse mode,
// the scaling pass. After reset the store is cleared, during which no request is
// taken. Inverse mode conjugates the twiddles, scales the real part by 1/n (floor)
// and returns a zero imaginary part.
`default_nettype none

module radix2_fft_ifft
	import rfft_pkg::*;
#(
	parameter int MAX_POINTS   = MAX_POINTS_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int TWIDDLE_BITS = TWIDDLE_BITS_DEF,
	localparam int AW  = $clog2(MAX_POINTS),
	localparam int IDW = ((2 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int ODW = ((2 * DATA_BITS + AW + 7) / 8) * 8,
	localparam int CW  = CTRL_BITS + 2 * SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IDW-1:0]           s_tdata,   // sample_re, sample_im
	input  logic                     s_tuser,   // req_type
	input  logic                     s_tlast,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [ODW-1:0]           m_tdata,   // out_re, out_im, out_index
	output logic                     m_tlast,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	logic          clearing;
	logic          push_valid;
	logic          push_ready;
	logic [CW-1:0] push_data;
	logic          q_valid;
	logic          q_pop;
	logic [CW-1:0] q_data;

	rfft_front #(
		.MaxPoints (MAX_POINTS),
		.SampleBits(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.clearing  (clearing),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	rfft_queue #(
		.Width(CW),
		.Depth(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_data  (q_data)
	);

	rfft_back #(
		.MaxPoints  (MAX_POINTS),
		.SampleBits (SAMPLE_BITS),
		.TwiddleBits(TWIDDLE_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.clearing(clearing),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

`default_nettype wire
